// File: rtl/mcg_pkg.sv
// Package for the month calendar grid block: shared types, constants and tables.
// No dependencies; used by every module of the block.
package mcg_pkg;

  localparam int unsigned MCG_QDEPTH = 2;

  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned WORK_W  = 15;
  localparam int unsigned RECIP_W = 16;
  localparam int unsigned PROD_W  = WORK_W + RECIP_W;

  // Reciprocals for division by 100 (shift 19) and by 7 (shift 18).
  localparam logic [RECIP_W-1:0] RECIP_100 = 16'd5243;
  localparam logic [RECIP_W-1:0] RECIP_7   = 16'd37450;

  localparam logic [WORK_W-1:0] YEAR_SHIFT = 15'd400;
  localparam logic [2:0]        LAST_COL   = 3'd6;

  typedef struct packed {
    logic             bad;
    logic [2:0]       lead;
    logic [DAY_W-1:0] len;
  } mcg_desc_t;

  // floor(31 * m / 12) where m is the month renumbered from March.
  function automatic logic [4:0] month_offset(input logic [MONTH_W-1:0] mon);
    logic [4:0] r;
    begin
      case (mon)
        4'd1:    r = 5'd28;
        4'd2:    r = 5'd31;
        4'd3:    r = 5'd2;
        4'd4:    r = 5'd5;
        4'd5:    r = 5'd7;
        4'd6:    r = 5'd10;
        4'd7:    r = 5'd12;
        4'd8:    r = 5'd15;
        4'd9:    r = 5'd18;
        4'd10:   r = 5'd20;
        4'd11:   r = 5'd23;
        4'd12:   r = 5'd25;
        default: r = 5'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mon,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    begin
      case (mon) inside
        4'd2:                          r = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:       r = 5'd30;
        default:                       r = 5'd31;
      endcase
      return r;
    end
  endfunction

endpackage

// File: rtl/mcg_front.sv
// Front end of the month calendar grid: accepts a request, classifies the month
// and works out the first weekday and month length. Depends on mcg_pkg.
module mcg_front
  import mcg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [MONTH_W-1:0] month,
  input  logic [YEAR_W-1:0]  year,
  output logic               d_valid,
  input  logic               d_ready,
  output mcg_desc_t          d_data
);

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_DIVY  = 5'b00010,
    F_DIVYR = 5'b00100,
    F_MOD   = 5'b01000,
    F_PUSH  = 5'b10000
  } front_state_t;

  front_state_t state, state_next;

  logic [MONTH_W-1:0] mon;
  logic [YEAR_W-1:0]  yr;
  logic [WORK_W-1:0]  y;
  logic               bad;
  logic [7:0]         q100y;
  logic [7:0]         q100yr;
  logic [WORK_W-1:0]  sum;
  logic [11:0]        q7;
  logic               leap;

  logic [WORK_W-1:0]  mul_a;
  logic [RECIP_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic               is_early;
  logic [WORK_W-1:0]  hundreds;
  logic [WORK_W-1:0]  rem7_wide;

  assign is_early = (month == 4'd1) || (month == 4'd2);

  // One shared multiplier; each state picks its operands.
  always_comb begin
    unique case (state)
      F_DIVY:  begin mul_a = y;                              mul_b = RECIP_100; end
      F_DIVYR: begin mul_a = {{(WORK_W-YEAR_W){1'b0}}, yr};  mul_b = RECIP_100; end
      F_MOD:   begin mul_a = sum;                            mul_b = RECIP_7;   end
      default: begin mul_a = '0;                             mul_b = '0;        end
    endcase
  end
  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign hundreds  = (WORK_W'(q100yr) << 6) + (WORK_W'(q100yr) << 5) + (WORK_W'(q100yr) << 2);
  assign rem7_wide = sum - ((WORK_W'(q7) << 3) - WORK_W'(q7));

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (push) state_next = ((month == 4'd0) || (month > 4'd12)) ? F_PUSH : F_DIVY;
      F_DIVY:  state_next = F_DIVYR;
      F_DIVYR: state_next = F_MOD;
      F_MOD:   state_next = F_PUSH;
      F_PUSH:  if (d_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        mon <= month;
        yr  <= year;
        bad <= (month == 4'd0) || (month > 4'd12);
        // Adding 400 years keeps the weekday and avoids negative values.
        y   <= WORK_W'(year) + YEAR_SHIFT - WORK_W'(is_early);
      end
      F_DIVY: begin
        q100y <= prod[26:19];
      end
      F_DIVYR: begin
        q100yr <= prod[26:19];
        sum    <= 15'd1 + y + (y >> 2) - WORK_W'(q100y) + WORK_W'(q100y >> 2)
                  + WORK_W'(month_offset(mon));
      end
      F_MOD: begin
        q7   <= prod[29:18];
        leap <= (yr[1:0] == 2'b00) &&
                ((WORK_W'(yr) != hundreds) || (q100yr[1:0] == 2'b00));
      end
      default: begin
      end
    endcase
  end

  assign full          = (state != F_IDLE);
  assign d_valid       = (state == F_PUSH);
  assign d_data.bad    = bad;
  assign d_data.lead   = bad ? 3'd0 : rem7_wide[2:0];
  assign d_data.len    = month_days(mon, leap);

endmodule

// File: rtl/mcg_fifo.sv
// Small descriptor queue between the front and back ends.
// Depends on mcg_pkg for the descriptor type.
module mcg_fifo
  import mcg_pkg::*;
#(
  parameter int unsigned DEPTH = MCG_QDEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  mcg_desc_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output mcg_desc_t rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mcg_desc_t          slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr, do_rd;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: rtl/mcg_back.sv
// Back end of the month calendar grid: turns a descriptor into grid cells,
// one per cycle into an output register while pop keeps it free. Depends on mcg_pkg.
module mcg_back
  import mcg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             d_valid,
  output logic             d_ready,
  input  mcg_desc_t        d_data,
  output logic             empty,
  input  logic             pop,
  output logic             is_day,
  output logic [DAY_W-1:0] day_number,
  output logic             row_end,
  output logic             last,
  output logic             bad_month
);

  logic             active;
  logic             bad;
  logic [2:0]       lead_left;
  logic [DAY_W-1:0] len;
  logic [DAY_W-1:0] day;
  logic [2:0]       col;
  logic             out_valid;
  logic             slot_free;
  logic             emit;
  logic             col_end;

  assign slot_free = !out_valid || pop;
  assign d_ready   = !active;
  assign emit      = active && slot_free;
  assign col_end   = (col == LAST_COL);
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (d_valid && !active) begin
        active <= 1'b1;
      end else if (emit && (bad || (lead_left == 3'd0 && day == len))) begin
        active <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_valid && !active) begin
      bad       <= d_data.bad;
      lead_left <= d_data.lead;
      len       <= d_data.len;
      day       <= 5'd1;
      col       <= 3'd0;
    end else if (emit) begin
      col <= col_end ? 3'd0 : col + 1'b1;
      if (bad) begin
        is_day     <= 1'b0;
        day_number <= '0;
        row_end    <= 1'b0;
        last       <= 1'b1;
        bad_month  <= 1'b1;
      end else if (lead_left != 3'd0) begin
        // Blank lead-in cell before the first day.
        lead_left  <= lead_left - 1'b1;
        is_day     <= 1'b0;
        day_number <= '0;
        row_end    <= col_end;
        last       <= 1'b0;
        bad_month  <= 1'b0;
      end else begin
        day        <= day + 1'b1;
        is_day     <= 1'b1;
        day_number <= day;
        row_end    <= col_end;
        last       <= (day == len);
        bad_month  <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/month_calendar_grid_top.sv
// Top level of the month calendar grid: front end, descriptor queue, back end.
// Depends on mcg_pkg, mcg_front, mcg_fifo and mcg_back.
//
//   Channel   Handshake        Payload
//   request   push / full      month[3:0], year[13:0]
//   cells     pop / empty      is_day, day_number[4:0], row_end, last, bad_month
//
// After a request is accepted, full stays high while the front end runs the
// divisions by 100 and by 7 through one shared multiplier (skipped for a bad
// month) and while it waits in F_PUSH until the queue takes the descriptor.
// The back end loads a descriptor, then emits one cell per cycle while pop keeps
// its output free: one cell for a bad month, else the lead-in blanks plus the days, up to 37 cells.
// While the back end drains a month, the front end prepares the next request.
// Reset is synchronous and clears the control state; stalls on pop hold the cell.
module month_calendar_grid_top
  import mcg_pkg::*;
#(
  parameter int unsigned QDEPTH = MCG_QDEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [MONTH_W-1:0] month,
  input  logic [YEAR_W-1:0]  year,
  output logic               empty,
  input  logic               pop,
  output logic               is_day,
  output logic [DAY_W-1:0]   day_number,
  output logic               row_end,
  output logic               last,
  output logic               bad_month
);

  logic      f_valid, f_ready;
  mcg_desc_t f_data;
  logic      b_valid, b_ready;
  mcg_desc_t b_data;

  mcg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .month   (month),
    .year    (year),
    .d_valid (f_valid),
    .d_ready (f_ready),
    .d_data  (f_data)
  );

  mcg_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  mcg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .d_valid    (b_valid),
    .d_ready    (b_ready),
    .d_data     (b_data),
    .empty      (empty),
    .pop        (pop),
    .is_day     (is_day),
    .day_number (day_number),
    .row_end    (row_end),
    .last       (last),
    .bad_month  (bad_month)
  );

endmodule

// File: tb/mcg_cell_checker.sv
// Checker for the month calendar grid: watches the request and cell channels,
// predicts the cells of each accepted request and compares them in order.
// Depends on mcg_pkg for the field widths.
`timescale 1ns / 1ps

module mcg_cell_checker
  import mcg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [MONTH_W-1:0] month,
  input  logic [YEAR_W-1:0]  year,
  input  logic               empty,
  input  logic               pop,
  input  logic               is_day,
  input  logic [DAY_W-1:0]   day_number,
  input  logic               row_end,
  input  logic               last,
  input  logic               bad_month,
  output int                 mismatches,
  output int                 pending
);

  localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic             is_day;
    logic [DAY_W-1:0] day_number;
    logic             row_end;
    logic             last;
    logic             bad_month;
  } grid_cell_t;

  grid_cell_t cells_due[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // Appends the whole run of cells that one request produces.
  task automatic predict_month_cells(input logic [MONTH_W-1:0] mon,
                                     input logic [YEAR_W-1:0] yr);
    int unsigned mn, yv, jan_feb, y_adj, m_adj, lead, len, pos;
    logic        leap;
    grid_cell_t  exp_cell;
    mn = mon;
    yv = yr;
    if (mn < 1 || mn > 12) begin
      exp_cell = '0;
      exp_cell.last      = 1'b1;
      exp_cell.bad_month = 1'b1;
      cells_due.push_back(exp_cell);
    end else begin
      // January and February count as months 11 and 12 of the previous year.
      // The 400-year offset keeps year 0 from going negative.
      jan_feb = (14 - mn) / 12;
      y_adj   = yv + 400 - jan_feb;
      m_adj   = mn + 12 * jan_feb - 2;
      lead    = (1 + y_adj + y_adj / 4 - y_adj / 100 + y_adj / 400 + (31 * m_adj) / 12) % 7;
      leap    = ((yv % 4 == 0) && (yv % 100 != 0)) || (yv % 400 == 0);
      len     = (mn == 2 && leap) ? 29 : DAYS_IN_MONTH[mn - 1];
      for (pos = 1; pos <= lead + len; pos++) begin
        exp_cell            = '0;
        exp_cell.is_day     = (pos > lead);
        exp_cell.day_number = (pos > lead) ? DAY_W'(pos - lead) : '0;
        exp_cell.row_end    = (pos % 7 == 0);
        exp_cell.last       = (pos == lead + len);
        cells_due.push_back(exp_cell);
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input logic [DAY_W-1:0] got);
    if ({27'd0, got} !== want) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    grid_cell_t want;
    if (!rst) begin
      // A cell leaving at this edge always belongs to an earlier request.
      if (pop && !empty) begin
        if (cells_due.size() == 0) begin
          mismatches++;
          $error("cell transaction with no expected cell (day_number %0d)", day_number);
        end else begin
          want = cells_due.pop_front();
          check_field("is_day", want.is_day, {4'd0, is_day});
          check_field("day_number", want.day_number, day_number);
          check_field("row_end", want.row_end, {4'd0, row_end});
          check_field("last", want.last, {4'd0, last});
          check_field("bad_month", want.bad_month, {4'd0, bad_month});
        end
      end
      if (push && !full)
        predict_month_cells(month, year);
    end
    pending = cells_due.size();
  end

endmodule

// File: tb/month_calendar_grid_top_tb.sv
// Testbench top for month_calendar_grid_top: clock, reset, request stimulus and
// cell pop pacing, with verdict. Depends on mcg_pkg, the block and mcg_cell_checker.
`timescale 1ns / 1ps

module month_calendar_grid_top_tb;
  import mcg_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PER_PHASE = 120;
  localparam int NUM_DIRECTED = 24;
  localparam int DIR_MONTH [NUM_DIRECTED] = '{
    1, 12, 2, 2, 2, 2, 3, 2, 1, 2, 3, 12,
    0, 13, 14, 15, 4, 5, 6, 7, 8, 9, 10, 11};
  // Extremes of the year, century and 400-year leap rules, a 37-cell month
  // (March 2025) and a month that fills exactly four rows (February 2015).
  localparam int DIR_YEAR [NUM_DIRECTED] = '{
    1, 9999, 2000, 1900, 2024, 2023, 2025, 2015, 0, 0, 0, 16383,
    2024, 2024, 1, 16383, 2021, 2022, 2023, 2024, 2025, 2026, 2027, 8191};

  logic               clk   = 1'b0;
  logic               rst   = 1'b1;
  logic               push  = 1'b0;
  logic               pop   = 1'b0;
  logic [MONTH_W-1:0] month = '0;
  logic [YEAR_W-1:0]  year  = '0;
  logic               full;
  logic               empty;
  logic               is_day;
  logic [DAY_W-1:0]   day_number;
  logic               row_end;
  logic               last;
  logic               bad_month;

  int mismatches;
  int pending;
  int cycles = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;

  always #10 clk = ~clk;

  month_calendar_grid_top uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .month(month), .year(year),
    .empty(empty), .pop(pop), .is_day(is_day), .day_number(day_number),
    .row_end(row_end), .last(last), .bad_month(bad_month)
  );

  mcg_cell_checker u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .month(month), .year(year),
    .empty(empty), .pop(pop), .is_day(is_day), .day_number(day_number),
    .row_end(row_end), .last(last), .bad_month(bad_month),
    .mismatches(mismatches), .pending(pending)
  );

  always @(negedge clk)
    pop <= ($urandom_range(99) >= pop_stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("month_calendar_grid_top_tb: FAIL");
      $finish;
    end
  end

  // Entered and left just after a falling edge; push stays high between
  // back-to-back requests.
  task automatic send_request(input logic [MONTH_W-1:0] m, input logic [YEAR_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push  <= 1'b1;
    month <= m;
    year  <= y;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_all_cells();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_request();
    logic [MONTH_W-1:0] m;
    logic [YEAR_W-1:0]  y;
    int                 pick;
    if ($urandom_range(99) < 12) begin
      pick = $urandom_range(3);
      m = (pick == 0) ? 4'd0 : MONTH_W'(12 + pick);
    end else begin
      m = MONTH_W'($urandom_range(12, 1));
    end
    pick = $urandom_range(99);
    if (pick < 75)
      y = YEAR_W'($urandom_range(9999, 1));
    else if (pick < 90)
      y = YEAR_W'($urandom_range(16383, 0));
    else if (pick < 95)
      y = YEAR_W'(400 * $urandom_range(40, 0) + 100 * $urandom_range(3, 0));
    else
      y = ($urandom_range(1) == 1) ? '1 : '0;
    send_request(m, y);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_request(MONTH_W'(DIR_MONTH[i]), YEAR_W'(DIR_YEAR[i]));
    wait_all_cells();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 75; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 75; end
        default: begin send_idle_pct = 9; pop_stall_pct = 9; end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
        send_random_request();
      wait_all_cells();
    end

    pop_stall_pct = 0;
    repeat (50) @(negedge clk);
    if (mismatches == 0)
      $display("month_calendar_grid_top_tb: PASS");
    else
      $display("month_calendar_grid_top_tb: FAIL");
    $finish;
  end

endmodule
